[rtl/kvt_pkg.sv]
// kvt_pkg: shared types, codes and widths of the integer key/value table
// used by kvt_key_store, kvt_value_store and integer_key_value_table_core
// no dependencies
`default_nettype none
package kvt_pkg;

  // default number of table entries
  localparam int DefaultCapacity = 64;

  // field widths
  localparam int ActionW  = 2;
  localparam int KeyW     = 64;
  localparam int ValW     = 64;
  localparam int StatusW  = 3;
  localparam int InDataW  = 136;
  localparam int OutDataW = 72;

  // request kinds; the fourth code changes nothing and reports not found
  typedef enum logic [ActionW-1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LOOKUP = 2'd2
  } action_t;

  // result codes
  typedef enum logic [StatusW-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  // controller states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_VREAD,
    S_FINISH
  } state_t;

endpackage
`default_nettype wire

[rtl/integer_key_value_table_core.sv]
// integer_key_value_table_core: top level of the integer key/value table
// depends on kvt_pkg, kvt_key_store and kvt_value_store
//
// usage: a request item enters on s_tvalid/s_tready/s_tdata (action, signed
// 64-bit key, 64-bit value) and one result item leaves on
// m_tvalid/m_tready/m_tdata (status, value_out). requests are handled one
// at a time; there is no overlap, so key and value memory accesses of two
// items never meet.
// each request walks the key memory one entry per cycle through its single
// read port: a scan that reads all CAPACITY entries and waits until the
// compare stage has drained, a decide step, a value read on a hit remove or
// lookup, and a finish step that loads the output register. the result and
// s_tready rise together, so the next item can be taken as the result shows.
// reset (rst, synchronous) starts a clearing pass that marks every entry
// free; s_tready stays low until it ends.
// the result sits in an output register: a new item is accepted while it
// waits, and only when the next result is ready and the receiver still
// stalls does the block hold in its finish state.
`default_nettype none
module integer_key_value_table_core #(
  parameter int CAPACITY = kvt_pkg::DefaultCapacity
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  // [1:0] action, [65:2] key, [129:66] value, [135:130] zero
  input  wire logic [kvt_pkg::InDataW-1:0]  s_tdata,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  // [2:0] status, [66:3] value_out, [71:67] zero
  output logic [kvt_pkg::OutDataW-1:0]      m_tdata
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  kvt_pkg::state_t state, state_next;

  // request registers
  kvt_pkg::action_t               req_action;
  logic signed [kvt_pkg::KeyW-1:0] req_key;
  logic [kvt_pkg::ValW-1:0]        req_value;

  // scan bookkeeping
  logic [CW-1:0] cnt;
  logic          chk_pending;
  logic [AW-1:0] chk_idx;
  logic          hit_found;
  logic [AW-1:0] hit_idx;
  logic          free_found;
  logic [AW-1:0] free_idx;

  // result and output registers
  kvt_pkg::status_t         res_status;
  logic [kvt_pkg::ValW-1:0] res_value;
  kvt_pkg::status_t         out_status;
  logic [kvt_pkg::ValW-1:0] out_value;

  // memory ports
  logic                            ks_rd_en;
  logic                            ks_rd_valid;
  logic signed [kvt_pkg::KeyW-1:0] ks_rd_key;
  logic                            ks_wr_en;
  logic [AW-1:0]                   ks_wr_addr;
  logic                            ks_wr_valid;
  logic                            vs_rd_en;
  logic [kvt_pkg::ValW-1:0]        vs_rd_data;
  logic                            vs_wr_en;

  logic in_fire;
  logic scan_issue;
  logic out_load;

  kvt_key_store #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_key_store (
    .clk      (clk),
    .rd_en    (ks_rd_en),
    .rd_addr  (cnt[AW-1:0]),
    .rd_valid (ks_rd_valid),
    .rd_key   (ks_rd_key),
    .wr_en    (ks_wr_en),
    .wr_addr  (ks_wr_addr),
    .wr_valid (ks_wr_valid),
    .wr_key   (req_key)
  );

  kvt_value_store #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_value_store (
    .clk     (clk),
    .rd_en   (vs_rd_en),
    .rd_addr (hit_idx),
    .rd_data (vs_rd_data),
    .wr_en   (vs_wr_en),
    .wr_addr (free_idx),
    .wr_data (req_value)
  );

  assign s_tready   = (state == kvt_pkg::S_IDLE);
  assign in_fire    = s_tvalid && s_tready;
  assign scan_issue = (state == kvt_pkg::S_SCAN) && (cnt != CW'(CAPACITY));
  assign out_load   = (state == kvt_pkg::S_FINISH) && (!m_tvalid || m_tready);
  assign m_tdata    = {5'b0, out_value, out_status};

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kvt_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory controls
  always_comb begin
    state_next  = state;
    ks_rd_en    = 1'b0;
    ks_wr_en    = 1'b0;
    ks_wr_addr  = free_idx;
    ks_wr_valid = 1'b0;
    vs_rd_en    = 1'b0;
    vs_wr_en    = 1'b0;
    unique case (state)
      kvt_pkg::S_CLEAR: begin
        ks_wr_en   = 1'b1;
        ks_wr_addr = cnt[AW-1:0];
        if (cnt == CW'(CAPACITY - 1)) begin
          state_next = kvt_pkg::S_IDLE;
        end
      end
      kvt_pkg::S_IDLE: begin
        if (in_fire) begin
          state_next = kvt_pkg::S_SCAN;
        end
      end
      kvt_pkg::S_SCAN: begin
        ks_rd_en = scan_issue;
        if (!scan_issue && !chk_pending) begin
          state_next = kvt_pkg::S_DECIDE;
        end
      end
      kvt_pkg::S_DECIDE: begin
        state_next = kvt_pkg::S_FINISH;
        case (req_action)
          kvt_pkg::ACT_INSERT: begin
            if (!hit_found && free_found) begin
              ks_wr_en    = 1'b1;
              ks_wr_valid = 1'b1;
              vs_wr_en    = 1'b1;
            end
          end
          kvt_pkg::ACT_REMOVE: begin
            if (hit_found) begin
              ks_wr_en   = 1'b1;
              ks_wr_addr = hit_idx;
              vs_rd_en   = 1'b1;
              state_next = kvt_pkg::S_VREAD;
            end
          end
          kvt_pkg::ACT_LOOKUP: begin
            if (hit_found) begin
              vs_rd_en   = 1'b1;
              state_next = kvt_pkg::S_VREAD;
            end
          end
          default: ;
        endcase
      end
      kvt_pkg::S_VREAD: begin
        state_next = kvt_pkg::S_FINISH;
      end
      kvt_pkg::S_FINISH: begin
        if (out_load) begin
          state_next = kvt_pkg::S_IDLE;
        end
      end
      default: state_next = kvt_pkg::S_IDLE;
    endcase
  end

  // counter: clearing pass address, then scan read address
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (in_fire) begin
      cnt <= '0;
    end else if (state == kvt_pkg::S_CLEAR || scan_issue) begin
      cnt <= cnt + CW'(1);
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_action <= kvt_pkg::action_t'(s_tdata[1:0]);
      req_key    <= s_tdata[kvt_pkg::KeyW+1:2];
      req_value  <= s_tdata[kvt_pkg::KeyW+kvt_pkg::ValW+1:kvt_pkg::KeyW+2];
    end
  end

  // scan compare: first matching valid entry and first free entry
  always_ff @(posedge clk) begin
    if (rst) begin
      chk_pending <= 1'b0;
      hit_found   <= 1'b0;
      free_found  <= 1'b0;
    end else if (in_fire) begin
      chk_pending <= 1'b0;
      hit_found   <= 1'b0;
      free_found  <= 1'b0;
    end else begin
      chk_pending <= scan_issue;
      if (chk_pending) begin
        if (ks_rd_valid && ks_rd_key == req_key && !hit_found) begin
          hit_found <= 1'b1;
          hit_idx   <= chk_idx;
        end
        if (!ks_rd_valid && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= chk_idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_issue) begin
      chk_idx <= cnt[AW-1:0];
    end
  end

  // result status and value
  always_ff @(posedge clk) begin
    if (state == kvt_pkg::S_DECIDE) begin
      res_value  <= '0;
      res_status <= kvt_pkg::ST_NOT_FOUND;
      case (req_action)
        kvt_pkg::ACT_INSERT: begin
          if (hit_found) begin
            res_status <= kvt_pkg::ST_DUPLICATE;
          end else if (free_found) begin
            res_status <= kvt_pkg::ST_INSERTED;
          end else begin
            res_status <= kvt_pkg::ST_FULL;
          end
        end
        kvt_pkg::ACT_REMOVE: begin
          if (hit_found) begin
            res_status <= kvt_pkg::ST_REMOVED;
          end
        end
        kvt_pkg::ACT_LOOKUP: begin
          if (hit_found) begin
            res_status <= kvt_pkg::ST_FOUND;
          end
        end
        default: ;
      endcase
    end else if (state == kvt_pkg::S_VREAD) begin
      res_value <= vs_rd_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= res_status;
      out_value  <= res_value;
    end
  end

`ifndef SYNTH
  // key memory is written only by the clearing pass or a decision
  a_key_write_phase: assert property (@(posedge clk) disable iff (rst)
    ks_wr_en |-> (state == kvt_pkg::S_CLEAR || state == kvt_pkg::S_DECIDE))
    else $error("key memory written outside clear or decide");

  // a new result appears only out of the finish state
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == kvt_pkg::S_FINISH)
    else $error("result raised outside finish state");

  // value_out is zero unless an entry was removed or found
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_status != kvt_pkg::ST_REMOVED && out_status != kvt_pkg::ST_FOUND)
      |-> out_value == '0)
    else $error("nonzero value_out without a hit");
`endif

endmodule
`default_nettype wire

[rtl/kvt_key_store.sv]
// kvt_key_store: synchronous memory of valid flag and key per entry,
// one write port and one read port with registered read data
// depends on kvt_pkg
`default_nettype none
module kvt_key_store #(
  parameter int CAPACITY = kvt_pkg::DefaultCapacity,
  parameter int AW       = $clog2(CAPACITY)
) (
  input  wire logic                        clk,
  input  wire logic                        rd_en,
  input  wire logic [AW-1:0]               rd_addr,
  output logic                             rd_valid,
  output logic signed [kvt_pkg::KeyW-1:0]  rd_key,
  input  wire logic                        wr_en,
  input  wire logic [AW-1:0]               wr_addr,
  input  wire logic                        wr_valid,
  input  wire logic signed [kvt_pkg::KeyW-1:0] wr_key
);

  logic [kvt_pkg::KeyW:0] mem [CAPACITY];
  logic [kvt_pkg::KeyW:0] rd_word;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_valid, wr_key};
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  assign rd_valid = rd_word[kvt_pkg::KeyW];
  assign rd_key   = rd_word[kvt_pkg::KeyW-1:0];

endmodule
`default_nettype wire

[rtl/kvt_value_store.sv]
// kvt_value_store: synchronous memory of the 64-bit value per entry,
// one write port and one read port with registered read data
// depends on kvt_pkg
`default_nettype none
module kvt_value_store #(
  parameter int CAPACITY = kvt_pkg::DefaultCapacity,
  parameter int AW       = $clog2(CAPACITY)
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [AW-1:0]            rd_addr,
  output logic [kvt_pkg::ValW-1:0]      rd_data,
  input  wire logic                     wr_en,
  input  wire logic [AW-1:0]            wr_addr,
  input  wire logic [kvt_pkg::ValW-1:0] wr_data
);

  logic [kvt_pkg::ValW-1:0] mem [CAPACITY];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire
